>>> rtl/ladrc_pkg.sv
package ladrc_pkg;

  typedef logic signed [63:0] wide_t;

  localparam wide_t WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] WMAX66 = 66'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] DMAX66 = 66'sh0_0000_0000_7FFF_FFFF;
  localparam logic [31:0] DT_MIN_VALID = 32'd4295;
  localparam logic [5:0] MUL_LAST = 6'd62;
  localparam logic [6:0] DIV_LAST = 7'd77;

  localparam logic [2:0] REG_WO  = 3'd0;
  localparam logic [2:0] REG_KP  = 3'd1;
  localparam logic [2:0] REG_B0  = 3'd2;
  localparam logic [2:0] REG_LIM = 3'd3;
  localparam logic [2:0] REG_DT  = 3'd4;

  typedef struct packed {
    logic start;
    logic sh32;
  } mul_ctl_t;

  function automatic logic [62:0] mag63(wide_t x);
    logic [63:0] n;
    n = -x;
    return x[63] ? n[62:0] : x[62:0];
  endfunction

  function automatic wide_t wsat(logic signed [65:0] x);
    if (x > WMAX66) return WIDE_MAX;
    else if (x < -WMAX66) return -WIDE_MAX;
    else return x[63:0];
  endfunction

  function automatic logic signed [31:0] dsat(logic signed [65:0] x);
    if (x > DMAX66) return 32'sh7FFF_FFFF;
    else if (x < -DMAX66 - 66'sd1) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

endpackage

>>> rtl/first_order_ladrc_speed_loop.sv
// First-order linear ADRC speed loop. A control item runs seven products
// through one bit-serial multiplier (63 steps plus load, round and handoff
// each) and, when the plant gain is nonzero, a 78-step restoring divider,
// with sequencing states between them. A clear item gives no result and an
// item with a too-small tick period skips the products. The next item is
// taken while a finished result still waits on the master side.
module first_order_ladrc_speed_loop import ladrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // speed_target, speed_measured, previous_drive
  input  logic [95:0] s_axis_tdata,
  // req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive, speed_estimate, disturbance_estimate
  output logic [95:0] m_axis_tdata,
  // clamped
  output logic        m_axis_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_E, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_DV, S_CL
  } st_e;

  st_e                st_q;
  logic [30:0]        wo_q, kp_q, lim_q;
  logic signed [31:0] b0_q;
  logic [31:0]        dt_q;
  logic signed [31:0] z1_q, z2_q, ref_q, meas_q, uprev_q;
  logic               primed_q;
  wide_t              e_q, t_q, mul_a_q, mul_b_q, div_num_q;
  mul_ctl_t           mul_ctl_q;
  logic               div_start_q;
  logic               out_valid_q, out_clamp_q;
  logic [95:0]        out_data_q;

  logic  mul_done, div_done;
  wide_t mul_res, div_res;
  wide_t lim64, u_cl;
  logic  cl;
  logic  s_acc;
  logic  mul_go, mul_sh32, div_go;

  ladrc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  ladrc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (b0_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign s_acc = s_axis_tvalid && s_axis_tready;

  assign mul_go   = (st_q == S_E) ||
                    (mul_done && (st_q inside {S_M1, S_M2, S_M3, S_M4, S_M5, S_M6}));
  assign mul_sh32 = st_q inside {S_M4, S_M5};
  assign div_go   = (st_q == S_M7) && mul_done && (b0_q != 32'sd0);

  always_comb begin
    lim64 = $signed({33'd0, lim_q});
    cl    = 1'b1;
    if (t_q > lim64) u_cl = lim64;
    else if (t_q < -lim64) u_cl = -lim64;
    else begin
      u_cl = t_q;
      cl   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      wo_q        <= '0;
      kp_q        <= '0;
      b0_q        <= '0;
      lim_q       <= 31'd655360;
      dt_q        <= '0;
      z1_q        <= '0;
      z2_q        <= '0;
      primed_q    <= 1'b0;
      mul_ctl_q   <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_ctl_q   <= '{start: mul_go, sh32: mul_sh32};
      div_start_q <= div_go;
      if (m_axis_tvalid && m_axis_tready && (st_q != S_CL)) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_WO:  wo_q  <= cfg_data_i[30:0];
          REG_KP:  kp_q  <= cfg_data_i[30:0];
          REG_B0:  b0_q  <= cfg_data_i;
          REG_LIM: lim_q <= cfg_data_i[30:0];
          REG_DT:  dt_q  <= cfg_data_i;
          default: ;
        endcase
      end
      case (st_q)
        S_IDLE: begin
          if (s_acc) begin
            if (s_axis_tuser) begin
              z1_q     <= '0;
              z2_q     <= '0;
              primed_q <= 1'b0;
            end else begin
              ref_q   <= s_axis_tdata[31:0];
              meas_q  <= s_axis_tdata[63:32];
              uprev_q <= s_axis_tdata[95:64];
              if (dt_q < DT_MIN_VALID) begin
                t_q  <= '0;
                st_q <= S_CL;
              end else begin
                if (!primed_q) begin
                  z1_q     <= s_axis_tdata[63:32];
                  z2_q     <= '0;
                  primed_q <= 1'b1;
                end
                st_q <= S_E;
              end
            end
          end
        end
        S_E: begin
          e_q     <= 64'(meas_q) - 64'(z1_q);
          mul_a_q <= $signed({32'd0, wo_q, 1'b0});
          mul_b_q <= 64'(meas_q) - 64'(z1_q);
          st_q    <= S_M1;
        end
        S_M1: if (mul_done) begin
          t_q     <= wsat(66'(z2_q) + 66'(mul_res));
          mul_a_q <= 64'(b0_q);
          mul_b_q <= 64'(uprev_q);
          st_q    <= S_M2;
        end
        S_M2: if (mul_done) begin
          t_q     <= wsat(66'(t_q) + 66'(mul_res));
          mul_a_q <= $signed({33'd0, wo_q});
          mul_b_q <= $signed({33'd0, wo_q});
          st_q    <= S_M3;
        end
        S_M3: if (mul_done) begin
          mul_a_q <= mul_res;
          mul_b_q <= e_q;
          st_q    <= S_M4;
        end
        S_M4: if (mul_done) begin
          e_q     <= mul_res;
          mul_a_q <= t_q;
          mul_b_q <= $signed({32'd0, dt_q});
          st_q    <= S_M5;
        end
        S_M5: if (mul_done) begin
          z1_q    <= dsat(66'(z1_q) + 66'(mul_res));
          mul_a_q <= e_q;
          mul_b_q <= $signed({32'd0, dt_q});
          st_q    <= S_M6;
        end
        S_M6: if (mul_done) begin
          z2_q    <= dsat(66'(z2_q) + 66'(mul_res));
          mul_a_q <= $signed({33'd0, kp_q});
          mul_b_q <= 64'(ref_q) - 64'(z1_q);
          st_q    <= S_M7;
        end
        S_M7: if (mul_done) begin
          if (b0_q != 32'sd0) begin
            div_num_q <= wsat(66'(mul_res) - 66'(z2_q));
            st_q      <= S_DV;
          end else begin
            t_q  <= mul_res;
            st_q <= S_CL;
          end
        end
        S_DV: if (div_done) begin
          t_q  <= div_res;
          st_q <= S_CL;
        end
        S_CL: begin
          if (!out_valid_q || m_axis_tready) begin
            out_data_q  <= {z2_q, z1_q, u_cl[31:0]};
            out_clamp_q <= cl;
            out_valid_q <= 1'b1;
            st_q        <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_clamp_q;

endmodule

>>> rtl/ladrc_mul.sv
module ladrc_mul import ladrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_ctl_t ctl_i,
  input  wide_t    a_i,
  input  wide_t    b_i,
  output logic     done_o,
  output wide_t    res_o
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} st_e;

  st_e          st_q;
  logic [5:0]   cnt_q;
  logic [125:0] acc_q;
  logic [62:0]  mc_q, mp_q;
  logic         neg_q, sh32_q, done_q;
  wide_t        res_q;

  logic [63:0] sum;
  logic        hi_nz, sat;
  logic [63:0] rr, mg;

  always_comb begin
    sum   = {1'b0, acc_q[125:63]} + {1'b0, (mp_q[0] ? mc_q : 63'd0)};
    hi_nz = sh32_q ? |acc_q[125:95] : |acc_q[125:79];
    rr    = sh32_q ? {1'b0, acc_q[94:32]} + {63'd0, acc_q[31]}
                   : {1'b0, acc_q[78:16]} + {63'd0, acc_q[15]};
    sat   = hi_nz | (|rr[63:62]);
    mg    = sat ? WIDE_MAX : rr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (st_q == M_FIN);
      case (st_q)
        M_IDLE: begin
          if (ctl_i.start) begin
            mc_q   <= mag63(a_i);
            mp_q   <= mag63(b_i);
            neg_q  <= a_i[63] ^ b_i[63];
            sh32_q <= ctl_i.sh32;
            acc_q  <= '0;
            cnt_q  <= '0;
            st_q   <= M_RUN;
          end
        end
        M_RUN: begin
          acc_q <= {sum, acc_q[62:1]};
          mp_q  <= {1'b0, mp_q[62:1]};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == MUL_LAST) st_q <= M_FIN;
        end
        M_FIN: begin
          res_q <= neg_q ? -$signed(mg) : $signed(mg);
          st_q  <= M_IDLE;
        end
        default: st_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/ladrc_div.sv
module ladrc_div import ladrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  wide_t              num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output wide_t              res_o
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} st_e;

  st_e         st_q;
  logic [6:0]  cnt_q;
  logic [77:0] dq_q;
  logic [31:0] r_q, ud_q;
  logic        neg_q, done_q;
  wide_t       res_q;

  logic [32:0] rs, rn;
  logic        ge, sat;
  logic [62:0] nm;
  logic [32:0] dn;
  logic [63:0] q;

  always_comb begin
    rs  = {r_q, dq_q[77]};
    ge  = rs >= {1'b0, ud_q};
    rn  = ge ? rs - {1'b0, ud_q} : rs;
    nm  = mag63(num_i);
    dn  = -{den_i[31], den_i};
    sat = |dq_q[77:62];
    q   = sat ? WIDE_MAX : {2'b00, dq_q[61:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (st_q == D_FIN);
      case (st_q)
        D_IDLE: begin
          if (start_i) begin
            dq_q  <= {nm[61:0], 16'd0};
            ud_q  <= den_i[31] ? dn[31:0] : den_i[31:0];
            neg_q <= num_i[63] ^ den_i[31];
            r_q   <= '0;
            cnt_q <= '0;
            st_q  <= D_RUN;
          end
        end
        D_RUN: begin
          r_q   <= rn[31:0];
          dq_q  <= {dq_q[76:0], ge};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == DIV_LAST) st_q <= D_FIN;
        end
        D_FIN: begin
          res_q <= neg_q ? -$signed(q) : $signed(q);
          st_q  <= D_IDLE;
        end
        default: st_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/ladrc_checker.sv
module ladrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("input taken while a step is in progress");

  a_clear_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready && !$rose(m_axis_tvalid))
    else $error("clear item produced a result or stalled input");

endmodule

bind first_order_ladrc_speed_loop ladrc_checker u_ladrc_checker (.*);

>>> bench/first_order_ladrc_speed_loop_tb.sv
module first_order_ladrc_speed_loop_tb import ladrc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;
  localparam int   SETTLE_CYCLES = 700;

  typedef struct {
    logic [31:0] drive;
    logic        clamped;
    logic [31:0] z1;
    logic [31:0] z2;
  } ctrl_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;

  first_order_ladrc_speed_loop dut (.*);

  always #5 clk_i = ~clk_i;

  logic [31:0] wo_q, kp_q, b0_q, lim_q, dt_q;
  longint z1_q, z2_q;
  bit primed_q;
  ctrl_result_t drive_expect_q[$];
  int errors = 0;
  int out_stall = 0;
  bit quiet_phase = 0;

  function automatic longint clip_wide(longint x);
    if (x > WIDE_MAX) return WIDE_MAX;
    if (x < -WIDE_MAX) return -WIDE_MAX;
    return x;
  endfunction

  function automatic longint clip_data(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [127:0] abs128(longint x);
    longint n;
    n = x < 0 ? -x : x;
    return {64'd0, n};
  endfunction

  function automatic longint mul_round(longint a, longint b, int sh);
    logic [127:0] p;
    longint r;
    p = abs128(a) * abs128(b) + (128'd1 << (sh - 1));
    p = p >> sh;
    r = (p > WIDE_MAX) ? WIDE_MAX : longint'(p[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint div_trunc(longint num, longint den);
    logic [127:0] q;
    longint r;
    q = (abs128(num) << 16) / abs128(den);
    r = (q > WIDE_MAX) ? WIDE_MAX : longint'(q[63:0]);
    return ((num < 0) != (den < 0)) ? -r : r;
  endfunction

  function automatic bit ctrl_step_predict(logic req, logic [95:0] d, output ctrl_result_t res);
    longint tgt, meas, uprev, b0, e, z1dot, z2dot, beta2, u0, u;
    tgt = longint'(signed'(d[31:0]));
    meas = longint'(signed'(d[63:32]));
    uprev = longint'(signed'(d[95:64]));
    b0 = longint'(signed'(b0_q));
    res.clamped = 1'b0;
    if (req == REQ_CLEAR) begin
      z1_q = 0;
      z2_q = 0;
      primed_q = 0;
      return 0;
    end
    if (dt_q < DT_MIN_VALID) begin
      res.drive = '0;
      res.z1 = z1_q[31:0];
      res.z2 = z2_q[31:0];
      return 1;
    end
    if (!primed_q) begin
      z1_q = meas;
      z2_q = 0;
      primed_q = 1;
    end
    e = meas - z1_q;
    z1dot = clip_wide(z2_q + mul_round(2 * longint'(wo_q), e, 16));
    z1dot = clip_wide(z1dot + mul_round(b0, uprev, 16));
    beta2 = mul_round(longint'(wo_q), longint'(wo_q), 16);
    z2dot = mul_round(beta2, e, 16);
    z1_q = clip_data(z1_q + mul_round(z1dot, longint'(dt_q), 32));
    z2_q = clip_data(z2_q + mul_round(z2dot, longint'(dt_q), 32));
    u0 = mul_round(longint'(kp_q), tgt - z1_q, 16);
    u = (b0 != 0) ? div_trunc(clip_wide(u0 - z2_q), b0) : u0;
    if (u > longint'(lim_q)) begin
      u = lim_q;
      res.clamped = 1'b1;
    end else if (u < -longint'(lim_q)) begin
      u = -longint'(lim_q);
      res.clamped = 1'b1;
    end
    res.drive = u[31:0];
    res.z1 = z1_q[31:0];
    res.z2 = z2_q[31:0];
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    ctrl_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = drive_expect_q.pop_front();
        if (m_axis_tdata[31:0] !== want.drive)
          report_mismatch("drive", m_axis_tdata[31:0], want.drive);
        if (m_axis_tuser !== want.clamped)
          report_mismatch("clamped", {31'd0, m_axis_tuser}, {31'd0, want.clamped});
        if (m_axis_tdata[63:32] !== want.z1)
          report_mismatch("speed_estimate", m_axis_tdata[63:32], want.z1);
        if (m_axis_tdata[95:64] !== want.z2)
          report_mismatch("disturbance_estimate", m_axis_tdata[95:64], want.z2);
      end
      out_stall = quiet_phase ? 0 : $urandom_range(0, 5);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WO:  wo_q = {1'b0, val[30:0]};
      REG_KP:  kp_q = {1'b0, val[30:0]};
      REG_B0:  b0_q = val;
      REG_LIM: lim_q = {1'b0, val[30:0]};
      REG_DT:  dt_q = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (drive_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(logic [31:0] wo, kp, b0, lim, dt);
    drain();
    write_reg(REG_WO, wo);
    write_reg(REG_KP, kp);
    write_reg(REG_B0, b0);
    write_reg(REG_LIM, lim);
    write_reg(REG_DT, dt);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(logic req, logic [31:0] tgt, meas, uprev);
    int gap;
    ctrl_result_t res;
    gap = quiet_phase ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {uprev, meas, tgt};
    do @(posedge clk_i); while (!s_axis_tready);
    if (ctrl_step_predict(req, {uprev, meas, tgt}, res)) drive_expect_q.push_back(res);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom_range(0, 2000 << 16) - (1000 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF | ($urandom_range(0, 1) << 31);
      2: return $urandom();
      default: return $urandom_range(1 << 16, 3000 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_plant();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(1 << 12, 200 << 16) * ($urandom_range(0, 1) ? 1 : -1);
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return DT_MIN_VALID - 1;
      2: return DT_MIN_VALID;
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(42950, 4294967);
    endcase
  endfunction

  task automatic test_after_reset();
    send_item(REQ_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(REQ_CLEAR, $urandom(), $urandom(), $urandom());
    send_item(REQ_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  task automatic test_tick_period_edges();
    configure(100 << 16, 50 << 16, 2 << 16, 10 << 16, DT_MIN_VALID - 1);
    send_item(REQ_STEP, 10 << 16, 3 << 16, 0);
    configure(100 << 16, 50 << 16, 2 << 16, 10 << 16, DT_MIN_VALID);
    send_item(REQ_STEP, 10 << 16, 3 << 16, 1 << 16);
    send_item(REQ_STEP, 10 << 16, 4 << 16, 2 << 16);
  endtask

  task automatic test_directed_extremes();
    configure(200 << 16, 100 << 16, 32'hFFF0_0000, 32'h7FFF_FFFF, 429497);
    send_item(REQ_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(REQ_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(REQ_STEP, 0, 0, 0);
    send_item(REQ_CLEAR, 0, 0, 0);
    send_item(REQ_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    configure(100 << 16, 100 << 16, 0, 5 << 16, 429497);
    send_item(REQ_STEP, 50 << 16, 1 << 16, 3 << 16);
    send_item(REQ_STEP, -(50 << 16), 1 << 16, 3 << 16);
    configure(100 << 16, 100 << 16, 1 << 16, 0, 429497);
    send_item(REQ_STEP, 50 << 16, 1 << 16, 0);
    send_item(REQ_STEP, 1 << 16, 1 << 16, 0);
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_CLEAR, 0, 0, 0);
    send_item(REQ_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(REQ_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(REQ_STEP, 32'h1234_5678, 32'h8765_4321, 32'h5555_AAAA);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0)
        configure(150 << 16, 80 << 16, 5 << 16, 20 << 16, 429497);
      else
        configure(pick_gain(), pick_gain(), pick_plant(), pick_gain(), pick_period());
      quiet_phase = (ph == 2);
      for (int n = 0; n < 125; n++)
        send_item($urandom_range(0, 19) == 0 ? REQ_CLEAR : REQ_STEP,
                  pick_speed(), pick_speed(), pick_speed());
    end
    quiet_phase = 0;
  endtask

  initial begin
    wo_q = 0; kp_q = 0; b0_q = 0; lim_q = 655360; dt_q = 0;
    z1_q = 0; z2_q = 0; primed_q = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_after_reset();
    test_tick_period_edges();
    test_directed_extremes();
    test_random_phases();
    drain();
    if (errors == 0) begin
      $display("first_order_ladrc_speed_loop regression: pass");
    end else begin
      $display("first_order_ladrc_speed_loop regression: fail");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("first_order_ladrc_speed_loop regression: fail");
    $finish;
  end

endmodule
